### hdl/scfl_pkg.sv
package scfl_pkg;

  localparam int MIN_UNIT_BYTES = 64;
  localparam int NUM_CLASSES    = 16;
  localparam int CLASS_SLOTS    = 64;
  localparam int ADDR_WIDTH     = 32;

  localparam int CIDX_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int HEAD_W      = $clog2(CLASS_SLOTS);
  localparam int FILL_W      = $clog2(CLASS_SLOTS + 1);
  localparam int SUM_W       = FILL_W + 1;
  localparam int STORE_DEPTH = NUM_CLASSES * CLASS_SLOTS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int STORE_W     = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [4:0]  LARGE_CLASS = 5'd16;
  localparam logic [31:0] MAX_UNIT    = 32'(MIN_UNIT_BYTES) << (NUM_CLASSES - 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam int CAP_TABLE [16] = '{50, 50, 50, 50, 50, 50, 50, 50, 50, 8, 4, 2, 1, 1, 1, 1};

  typedef enum logic [2:0] {
    KIND_REUSED,
    KIND_FRESH_SMALL,
    KIND_FRESH_LARGE,
    KIND_NULL,
    KIND_POOLED,
    KIND_RELEASED,
    KIND_INVALID
  } kind_t;

  typedef enum logic [2:0] {
    OP_NULL,
    OP_ALLOC_SMALL,
    OP_ALLOC_LARGE,
    OP_FREE_SMALL,
    OP_FREE_LARGE,
    OP_INVALID
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  cls;
    logic [31:0] unit;
    logic [31:0] addr;
  } cmd_t;

  function automatic logic [31:0] unit_of(input logic [3:0] k);
    return 32'(MIN_UNIT_BYTES) << k;
  endfunction

  function automatic logic [FILL_W-1:0] slot_cap(input logic [3:0] k);
    int c;
    c = CAP_TABLE[k];
    if (c > CLASS_SLOTS) c = CLASS_SLOTS;
    return FILL_W'(c);
  endfunction

endpackage

### hdl/size_class_free_list_pool_core.sv
// Pool of returned block addresses kept in 16 power-of-two size classes. Each
// accepted word gives exactly one result word. The front end classifies a
// word in the cycle it is taken and drops it into a two-entry queue, so up to
// two words can be taken ahead of the back end while a result waits. The back
// end retires one word per cycle while its results are taken, except an
// allocate that reuses a pooled address, which waits in a pop state for the
// address store, a single memory with a registered read port. A result is
// registered as its word leaves the queue; a reuse also passes the store's
// read register. The running totals shown with a result are the values after
// that word. The address store needs no clearing after reset; the block is ready at once.
module size_class_free_list_pool_core
  import scfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] request_size,
  input  logic [31:0] block_address,
  input  logic [4:0]  block_class,
  input  logic [31:0] block_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] reused_address,
  output logic [4:0]  size_class,
  output logic [31:0] unit_bytes,
  output logic [47:0] allocated_total,
  output logic [39:0] pooled_total,
  output logic [31:0] allocations_done,
  output logic [31:0] frees_done
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_ready = !q_full;

  scfl_front u_front (
    .action        (action),
    .request_size  (request_size),
    .block_address (block_address),
    .block_class   (block_class),
    .block_size    (block_size),
    .cmd           (front_cmd)
  );

  scfl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .wr_cmd    (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .rd_cmd    (q_cmd),
    .not_empty (q_valid)
  );

  scfl_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .reused_address   (reused_address),
    .size_class       (size_class),
    .unit_bytes       (unit_bytes),
    .allocated_total  (allocated_total),
    .pooled_total     (pooled_total),
    .allocations_done (allocations_done),
    .frees_done       (frees_done)
  );

endmodule

### hdl/scfl_front.sv
module scfl_front
  import scfl_pkg::*;
(
  input  logic        action,
  input  logic [31:0] request_size,
  input  logic [31:0] block_address,
  input  logic [4:0]  block_class,
  input  logic [31:0] block_size,
  output cmd_t        cmd
);

  logic [CIDX_W-1:0] k_sel;
  logic              fits;
  logic              hdr_ok;

  // smallest class whose unit covers the request
  always_comb begin
    k_sel = '0;
    fits  = 1'b0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (request_size <= unit_of(4'(k))) begin
        k_sel = CIDX_W'(k);
        fits  = 1'b1;
      end
    end
  end

  always_comb begin
    if (block_class == LARGE_CLASS) begin
      hdr_ok = block_size > MAX_UNIT;
    end else begin
      hdr_ok = (block_class < 5'(NUM_CLASSES)) && (block_size <= MAX_UNIT);
    end
  end

  always_comb begin
    cmd.op   = OP_NULL;
    cmd.cls  = '0;
    cmd.unit = '0;
    cmd.addr = block_address;
    if (action == ACT_ALLOC) begin
      if (request_size != '0) begin
        if (!fits) begin
          cmd.op   = OP_ALLOC_LARGE;
          cmd.cls  = LARGE_CLASS;
          cmd.unit = request_size;
        end else begin
          cmd.op   = OP_ALLOC_SMALL;
          cmd.cls  = 5'(k_sel);
          cmd.unit = unit_of(4'(k_sel));
        end
      end
    end else if (block_address != '0) begin
      cmd.cls  = block_class;
      cmd.unit = block_size;
      if (!hdr_ok) begin
        cmd.op = OP_INVALID;
      end else if (block_class == LARGE_CLASS) begin
        cmd.op = OP_FREE_LARGE;
      end else begin
        cmd.op = OP_FREE_SMALL;
      end
    end
  end

endmodule

### hdl/scfl_queue.sv
module scfl_queue
  import scfl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic not_empty
);

  cmd_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = count == Q_CNT_W'(Q_DEPTH);
  assign not_empty = count != '0;
  assign rd_cmd    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/scfl_back.sv
module scfl_back
  import scfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] reused_address,
  output logic [4:0]  size_class,
  output logic [31:0] unit_bytes,
  output logic [47:0] allocated_total,
  output logic [39:0] pooled_total,
  output logic [31:0] allocations_done,
  output logic [31:0] frees_done
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t            state;
  logic [HEAD_W-1:0] class_head [NUM_CLASSES];
  logic [FILL_W-1:0] class_fill [NUM_CLASSES];
  logic [STORE_W-1:0] store [STORE_DEPTH];
  logic [STORE_W-1:0] rd_data;
  logic [47:0]       bytes_out;
  logic [39:0]       bytes_pooled;
  logic [31:0]       alloc_tally;
  logic [31:0]       free_tally;
  kind_t             kind;

  logic              out_free;
  logic              take;
  logic [CIDX_W-1:0] cidx;
  logic [HEAD_W-1:0] cur_head;
  logic [FILL_W-1:0] cur_fill;
  logic              pop_hit;
  logic              push_hit;
  logic [SUM_W-1:0]  push_sum;
  logic [HEAD_W-1:0] push_pos;
  logic [HEAD_W-1:0] head_inc;
  logic [STORE_AW-1:0] mem_addr;

  assign out_free = !out_valid || out_ready;
  assign take     = (state == S_IDLE) && q_valid && out_free;
  assign q_pop    = take;
  assign cidx     = CIDX_W'(q_cmd.cls);
  assign cur_head = class_head[cidx];
  assign cur_fill = class_fill[cidx];
  assign pop_hit  = take && (q_cmd.op == OP_ALLOC_SMALL) && (cur_fill != '0);
  assign push_hit = take && (q_cmd.op == OP_FREE_SMALL) && (cur_fill < slot_cap(4'(cidx)));

  // tail slot of the class ring
  always_comb begin
    push_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
    if (push_sum >= SUM_W'(CLASS_SLOTS)) begin
      push_pos = HEAD_W'(push_sum - SUM_W'(CLASS_SLOTS));
    end else begin
      push_pos = HEAD_W'(push_sum);
    end
    head_inc = (cur_head == HEAD_W'(CLASS_SLOTS - 1)) ? '0 : cur_head + 1'b1;
    mem_addr = STORE_AW'(cidx) * STORE_AW'(CLASS_SLOTS)
             + STORE_AW'(pop_hit ? cur_head : push_pos);
  end

  always_ff @(posedge clk) begin
    if (push_hit) begin
      store[mem_addr] <= q_cmd.addr[STORE_W-1:0];
    end
    if (pop_hit) begin
      rd_data <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      bytes_out    <= '0;
      bytes_pooled <= '0;
      alloc_tally  <= '0;
      free_tally   <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_head[i] <= '0;
        class_fill[i] <= '0;
      end
    end else begin
      // word goes out at take, or for a reuse once the store read lands
      if (take) begin
        out_valid <= !pop_hit;
      end else if ((state == S_POP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            reused_address <= '0;
            size_class     <= q_cmd.cls;
            unit_bytes     <= q_cmd.unit;
            case (q_cmd.op)
              OP_NULL: begin
                kind <= KIND_NULL;
              end
              OP_ALLOC_LARGE: begin
                kind        <= KIND_FRESH_LARGE;
                alloc_tally <= alloc_tally + 1'b1;
                bytes_out   <= bytes_out + 48'(q_cmd.unit);
              end
              OP_ALLOC_SMALL: begin
                alloc_tally <= alloc_tally + 1'b1;
                bytes_out   <= bytes_out + 48'(q_cmd.unit);
                if (pop_hit) begin
                  state            <= S_POP;
                  class_head[cidx] <= head_inc;
                  class_fill[cidx] <= cur_fill - 1'b1;
                  bytes_pooled     <= bytes_pooled - 40'(q_cmd.unit);
                end else begin
                  kind <= KIND_FRESH_SMALL;
                end
              end
              OP_FREE_SMALL: begin
                free_tally <= free_tally + 1'b1;
                bytes_out  <= bytes_out - 48'(q_cmd.unit);
                if (push_hit) begin
                  kind             <= KIND_POOLED;
                  class_fill[cidx] <= cur_fill + 1'b1;
                  bytes_pooled     <= bytes_pooled + 40'(unit_of(4'(cidx)));
                end else begin
                  kind <= KIND_RELEASED;
                end
              end
              OP_FREE_LARGE: begin
                kind       <= KIND_RELEASED;
                free_tally <= free_tally + 1'b1;
                bytes_out  <= bytes_out - 48'(q_cmd.unit);
              end
              default: begin
                kind <= KIND_INVALID;
              end
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            kind           <= KIND_REUSED;
            reused_address <= 32'(rd_data);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_kind      = kind;
  assign allocated_total  = bytes_out;
  assign pooled_total     = bytes_pooled;
  assign allocations_done = alloc_tally;
  assign frees_done       = free_tally;

endmodule
